// ----- rtl/pfsw_pkg.sv -----
// pfsw_pkg: shared sizes, payload types and arithmetic helpers
// for the patch spectrum block; no dependencies
package pfsw_pkg;

	localparam int PATCH_SIZE = 32;
	localparam int LG         = $clog2(PATCH_SIZE);
	localparam int NBINS      = PATCH_SIZE * PATCH_SIZE;
	localparam int ADDR_W     = 2 * LG;
	localparam int STG_W      = $clog2(LG);
	localparam int TW_W       = 6;
	localparam int CFG_W      = 10;
	localparam int BIN_W      = 48;
	localparam logic [CFG_W-1:0] WEIGHT_RESET = 10'd128;

	typedef struct packed {
		logic signed [31:0] re;
		logic signed [31:0] im;
	} cbin_t;

	typedef struct packed {
		logic signed [BIN_W-1:0] re;
		logic signed [BIN_W-1:0] im;
	} wbin_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		cbin_t             data;
	} load_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} bin_rd_t;

	typedef struct packed {
		logic busy;
		logic valid;
	} wstat_t;

	// q15 quarter-wave cosine, 1.0 is 32768
	function automatic logic signed [16:0] quarter_cos(input logic [4:0] t);
		logic signed [16:0] v;
		case (t)
			5'd0:    v = 17'sd32768;
			5'd1:    v = 17'sd32610;
			5'd2:    v = 17'sd32138;
			5'd3:    v = 17'sd31357;
			5'd4:    v = 17'sd30274;
			5'd5:    v = 17'sd28899;
			5'd6:    v = 17'sd27246;
			5'd7:    v = 17'sd25330;
			5'd8:    v = 17'sd23170;
			5'd9:    v = 17'sd20788;
			5'd10:   v = 17'sd18205;
			5'd11:   v = 17'sd15447;
			5'd12:   v = 17'sd12540;
			5'd13:   v = 17'sd9512;
			5'd14:   v = 17'sd6393;
			5'd15:   v = 17'sd3212;
			default: v = 17'sd0;
		endcase
		return v;
	endfunction

	// cosine on a 64-point circle
	function automatic logic signed [16:0] cos64(input logic [TW_W-1:0] t);
		logic signed [16:0] v;
		if (t <= 6'd16) begin
			v = quarter_cos(5'(t));
		end else if (t <= 6'd32) begin
			v = -quarter_cos(5'(6'd32 - t));
		end else if (t <= 6'd48) begin
			v = -quarter_cos(5'(t - 6'd32));
		end else begin
			v = quarter_cos(5'(7'd64 - 7'(t)));
		end
		return v;
	endfunction

	function automatic logic [LG-1:0] bit_rev(input logic [LG-1:0] i);
		logic [LG-1:0] r;
		for (int b = 0; b < LG; b++) begin
			r[b] = i[LG-1-b];
		end
		return r;
	endfunction

	// q30 values of 2^(2^-k), k = 1..10
	function automatic logic [30:0] exp_root(input logic [3:0] i);
		logic [30:0] v;
		case (i)
			4'd0:    v = 31'd1518500250;
			4'd1:    v = 31'd1276901417;
			4'd2:    v = 31'd1170923762;
			4'd3:    v = 31'd1121280436;
			4'd4:    v = 31'd1097253710;
			4'd5:    v = 31'd1085434107;
			4'd6:    v = 31'd1079572136;
			4'd7:    v = 31'd1076653033;
			4'd8:    v = 31'd1075196444;
			4'd9:    v = 31'd1074468889;
			default: v = 31'd1073741824;
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > 36'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -36'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// scale magnitude by 2^(gi-30), round half up, saturate, apply sign
	function automatic logic [BIN_W-1:0] weigh(input logic [63:0] mag, input logic neg,
			input logic [6:0] gi);
		logic [63:0] cap;
		logic [6:0]  s;
		logic [4:0]  r;
		logic [64:0] rnd;
		logic [63:0] m;
		logic [63:0] o;
		cap = neg ? 64'h0000_8000_0000_0000 : 64'h0000_7fff_ffff_ffff;
		s   = gi - 7'd30;
		r   = 5'(7'd30 - gi);
		rnd = '0;
		if (mag == '0) begin
			m = '0;
		end else if (gi >= 7'd30) begin
			if (s >= 7'd48 || mag > (cap >> s)) m = cap;
			else m = mag << s;
		end else begin
			rnd = ({1'b0, mag} + (65'd1 << (r - 5'd1))) >> r;
			m   = (rnd > {1'b0, cap}) ? cap : rnd[63:0];
		end
		o = neg ? (64'd0 - m) : m;
		return o[BIN_W-1:0];
	endfunction

endpackage

// ----- rtl/pfsw_if.sv -----
// pfsw_in_if / pfsw_out_if: valid/ready channels of the patch spectrum block
// no dependencies
interface pfsw_in_if;
	logic               valid;
	logic               ready;
	logic               action;
	logic signed [15:0] sample_re;
	logic signed [15:0] sample_im;
	modport source (output valid, action, sample_re, sample_im, input ready);
	modport sink (input valid, action, sample_re, sample_im, output ready);
endinterface

interface pfsw_out_if;
	logic               valid;
	logic               ready;
	logic signed [47:0] bin_re;
	logic signed [47:0] bin_im;
	logic               last_bin;
	modport source (output valid, bin_re, bin_im, last_bin, input ready);
	modport sink (input valid, bin_re, bin_im, last_bin, output ready);
endinterface

// ----- rtl/pfsw_fft.sv -----
// pfsw_fft: spectrum store and in-place 2-d radix-2 fft sequencer
// depends on pfsw_pkg
module pfsw_fft (
	input  logic              clk,
	input  logic              arst_n,
	input  pfsw_pkg::load_wr_t ld,
	input  pfsw_pkg::bin_rd_t  rd,
	input  logic              start,
	output logic              done,
	output pfsw_pkg::cbin_t    rdata
);
	import pfsw_pkg::*;

	typedef enum logic [6:0] {
		F_IDLE = 7'b0000001,
		F_RDA  = 7'b0000010,
		F_RDB  = 7'b0000100,
		F_MUL  = 7'b0001000,
		F_ADD  = 7'b0010000,
		F_WRA  = 7'b0100000,
		F_WRB  = 7'b1000000
	} fstate_t;

	fstate_t            st_q;
	logic               swap_q;
	logic               pass_q;
	logic [LG-1:0]      line_q;
	logic [LG-1:0]      ctr_q;
	logic [STG_W-1:0]   stage_q;
	logic               done_q;

	cbin_t              mem [NBINS];
	cbin_t              rdata_q;
	cbin_t              a_q;
	cbin_t              b_q;
	logic signed [48:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
	logic signed [34:0] tr_q, ti_q;

	logic [LG-1:0]      half, half_mask, low, idx_a, idx_b;
	logic [TW_W-1:0]    tw_idx;
	logic signed [16:0] wr, wi;
	logic [ADDR_W-1:0]  addr_a, addr_b;
	logic               skip, adv, last_ctr, last_stage, last_line, finish;
	logic signed [49:0] sum_r, sum_i;
	cbin_t              bf_add, bf_sub;

	logic               mem_re, mem_we;
	logic [ADDR_W-1:0]  mem_raddr, mem_waddr;
	cbin_t              mem_wdata;

	// butterfly / swap addressing within the current line
	always_comb begin
		half      = LG'(1) << stage_q;
		half_mask = half - LG'(1);
		low       = ctr_q & half_mask;
		if (swap_q) begin
			idx_a = ctr_q;
			idx_b = bit_rev(ctr_q);
		end else begin
			idx_a = ((ctr_q & ~half_mask) << 1) | low;
			idx_b = idx_a | half;
		end
		tw_idx = TW_W'(low) << (3'(TW_W - 1) - 3'(stage_q));
		wr     = cos64(tw_idx);
		wi     = -cos64(tw_idx + 6'd48);
		addr_a = pass_q ? {idx_a, line_q} : {line_q, idx_a};
		addr_b = pass_q ? {idx_b, line_q} : {line_q, idx_b};
	end

	assign skip       = swap_q && (idx_b <= idx_a);
	assign adv        = (st_q == F_RDA && skip) || (st_q == F_WRB);
	assign last_ctr   = swap_q ? (ctr_q == LG'(PATCH_SIZE - 1)) : (ctr_q == LG'(PATCH_SIZE / 2 - 1));
	assign last_stage = stage_q == STG_W'(LG - 1);
	assign last_line  = line_q == LG'(PATCH_SIZE - 1);
	assign finish     = adv && last_ctr && !swap_q && last_stage && last_line && pass_q;

	assign sum_r = 50'(p_rr_q) - 50'(p_ii_q) + 50'sd16384;
	assign sum_i = 50'(p_ri_q) + 50'(p_ir_q) + 50'sd16384;

	always_comb begin
		bf_add.re = sat32(36'(a_q.re) + 36'(tr_q));
		bf_add.im = sat32(36'(a_q.im) + 36'(ti_q));
		bf_sub.re = sat32(36'(a_q.re) - 36'(tr_q));
		bf_sub.im = sat32(36'(a_q.im) - 36'(ti_q));
	end

	// single read port and single write port
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = addr_a;
		mem_we    = 1'b0;
		mem_waddr = addr_a;
		mem_wdata = bf_add;
		unique case (st_q)
			F_IDLE: begin
				mem_re    = rd.en;
				mem_raddr = rd.addr;
				mem_we    = ld.we;
				mem_waddr = ld.addr;
				mem_wdata = ld.data;
			end
			F_RDA: begin
				mem_re = !skip;
			end
			F_RDB: begin
				mem_re    = 1'b1;
				mem_raddr = addr_b;
			end
			F_WRA: begin
				mem_we    = 1'b1;
				mem_wdata = swap_q ? b_q : bf_add;
			end
			F_WRB: begin
				mem_we    = 1'b1;
				mem_waddr = addr_b;
				mem_wdata = swap_q ? a_q : bf_sub;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rdata_q <= mem[mem_raddr];
	end

	assign rdata = rdata_q;
	assign done  = done_q;

	// datapath registers
	always_ff @(posedge clk) begin
		if (st_q == F_RDB) a_q <= rdata_q;
		if (st_q == F_MUL) begin
			b_q    <= rdata_q;
			p_rr_q <= $signed(rdata_q.re) * wr;
			p_ii_q <= $signed(rdata_q.im) * wi;
			p_ri_q <= $signed(rdata_q.re) * wi;
			p_ir_q <= $signed(rdata_q.im) * wr;
		end
		if (st_q == F_ADD) begin
			tr_q <= 35'(sum_r >>> 15);
			ti_q <= 35'(sum_i >>> 15);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= F_IDLE;
			swap_q  <= 1'b1;
			pass_q  <= 1'b0;
			line_q  <= '0;
			ctr_q   <= '0;
			stage_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= finish;
			unique case (st_q)
				F_IDLE: if (start) begin
					st_q    <= F_RDA;
					swap_q  <= 1'b1;
					pass_q  <= 1'b0;
					line_q  <= '0;
					ctr_q   <= '0;
					stage_q <= '0;
				end
				F_RDA: if (!skip) st_q <= F_RDB;
				F_RDB: st_q <= F_MUL;
				F_MUL: st_q <= swap_q ? F_WRA : F_ADD;
				F_ADD: st_q <= F_WRA;
				F_WRA: st_q <= F_WRB;
				F_WRB: st_q <= finish ? F_IDLE : F_RDA;
				default: st_q <= F_IDLE;
			endcase
			if (adv) begin
				if (!last_ctr) begin
					ctr_q <= ctr_q + LG'(1);
				end else begin
					ctr_q <= '0;
					if (swap_q) begin
						swap_q  <= 1'b0;
						stage_q <= '0;
					end else if (!last_stage) begin
						stage_q <= stage_q + STG_W'(1);
					end else begin
						swap_q  <= 1'b1;
						stage_q <= '0;
						if (!last_line) begin
							line_q <= line_q + LG'(1);
						end else begin
							line_q <= '0;
							pass_q <= ~pass_q;
						end
					end
				end
			end
		end
	end

endmodule

// ----- rtl/pfsw_weight.sv -----
// pfsw_weight: multi-cycle power-law weighting of one bin (log2, scale, exp2)
// depends on pfsw_pkg
module pfsw_weight (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  pfsw_pkg::cbin_t              x,
	input  logic [pfsw_pkg::CFG_W-1:0]  alpha,
	input  logic                        take,
	output pfsw_pkg::wstat_t             stat,
	output pfsw_pkg::wbin_t              res
);
	import pfsw_pkg::*;

	typedef enum logic [9:0] {
		W_IDLE  = 10'b0000000001,
		W_SQR   = 10'b0000000010,
		W_SUM   = 10'b0000000100,
		W_NORM  = 10'b0000001000,
		W_LOG   = 10'b0000010000,
		W_GAIN  = 10'b0000100000,
		W_EXP   = 10'b0001000000,
		W_MAG   = 10'b0010000000,
		W_SHIFT = 10'b0100000000,
		W_DONE  = 10'b1000000000
	} wstate_t;

	wstate_t            st_q;
	logic [3:0]         step_q;
	cbin_t              x_q;
	logic [62:0]        sq_re_q, sq_im_q;
	logic [63:0]        norm_q;
	logic [5:0]         lz_q;
	logic [30:0]        y_q;
	logic [9:0]         frac_q;
	logic [6:0]         gi_q;
	logic [9:0]         gfr_q;
	logic [31:0]        mant_q;
	logic [63:0]        mag_re_q, mag_im_q;
	wbin_t              res_q;

	logic signed [63:0] sq_re, sq_im;
	logic [6:0]         amt;
	logic               top_zero;
	logic [30:0]        y_src;
	logic [61:0]        ysq;
	logic [15:0]        lval;
	logic [25:0]        gp;
	logic [62:0]        mprod;
	logic [31:0]        abs_re, abs_im;

	always_comb begin
		sq_re    = $signed(x_q.re) * $signed(x_q.re);
		sq_im    = $signed(x_q.im) * $signed(x_q.im);
		amt      = 7'd32 >> step_q;
		top_zero = (norm_q >> (7'd64 - amt)) == '0;
		y_src    = (step_q == 4'd0) ? norm_q[63:33] : y_q;
		ysq      = 62'(y_src) * 62'(y_src);
		lval     = {~lz_q, frac_q};
		gp       = 26'(lval) * 26'(alpha) + 26'd256;
		mprod    = 63'(mant_q) * 63'(exp_root(step_q)) + 63'(1 << 29);
		abs_re   = x_q.re[31] ? (32'd0 - x_q.re) : x_q.re;
		abs_im   = x_q.im[31] ? (32'd0 - x_q.im) : x_q.im;
	end

	assign stat.busy  = st_q != W_IDLE;
	assign stat.valid = st_q == W_DONE;
	assign res        = res_q;

	always_ff @(posedge clk) begin
		unique case (st_q)
			W_IDLE: if (start) x_q <= x;
			W_SQR: begin
				sq_re_q <= sq_re[62:0];
				sq_im_q <= sq_im[62:0];
				res_q   <= '0;
			end
			W_SUM: begin
				norm_q <= {1'b0, sq_re_q} + {1'b0, sq_im_q};
				lz_q   <= '0;
			end
			W_NORM: begin
				if (top_zero) begin
					norm_q <= norm_q << amt;
					lz_q   <= lz_q + 6'(amt);
				end
				frac_q <= '0;
			end
			W_LOG: begin
				if (ysq[61]) begin
					y_q    <= ysq[61:31];
					frac_q <= {frac_q[8:0], 1'b1};
				end else begin
					y_q    <= ysq[60:30];
					frac_q <= {frac_q[8:0], 1'b0};
				end
			end
			W_GAIN: begin
				gi_q   <= gp[25:19];
				gfr_q  <= gp[18:9];
				mant_q <= 32'h4000_0000;
			end
			W_EXP: begin
				if (gfr_q[9]) mant_q <= mprod[61:30];
				gfr_q <= {gfr_q[8:0], 1'b0};
			end
			W_MAG: begin
				mag_re_q <= 64'(abs_re) * 64'(mant_q);
				mag_im_q <= 64'(abs_im) * 64'(mant_q);
			end
			W_SHIFT: begin
				res_q.re <= weigh(mag_re_q, x_q.re[31], gi_q);
				res_q.im <= weigh(mag_im_q, x_q.im[31], gi_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= W_IDLE;
			step_q <= '0;
		end else begin
			unique case (st_q)
				W_IDLE: if (start) st_q <= W_SQR;
				W_SQR: begin
					// zero bin gives zero parts
					st_q <= (x_q.re == '0 && x_q.im == '0) ? W_DONE : W_SUM;
				end
				W_SUM: begin
					st_q   <= W_NORM;
					step_q <= '0;
				end
				W_NORM: begin
					if (step_q == 4'd5) begin
						st_q   <= W_LOG;
						step_q <= '0;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				W_LOG: begin
					if (step_q == 4'd9) begin
						st_q   <= W_GAIN;
						step_q <= '0;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				W_GAIN: begin
					st_q   <= W_EXP;
					step_q <= '0;
				end
				W_EXP: begin
					if (step_q == 4'd9) begin
						st_q   <= W_MAG;
						step_q <= '0;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				W_MAG:   st_q <= W_SHIFT;
				W_SHIFT: st_q <= W_DONE;
				W_DONE:  if (take) st_q <= W_IDLE;
				default: st_q <= W_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/patch_fft_spectral_weighting.sv -----
// patch_fft_spectral_weighting: load a patch, 2-d fft in place, read weighted bins
// depends on pfsw_pkg, pfsw_if, pfsw_fft, pfsw_weight
// load: one word per cycle; the last load starts the fft, which works through the store's
//   single read port: a swap reads both words of a pair and writes them back crossed, and
//   a butterfly reads both words, multiplies, adds and writes both results
// read: a bin is offered once the iterative weight unit is through with its read word (a
//   zero bin skips from squaring to done); the next read word is taken once the previous
//   result moves to the output register, so no new read word is taken while one is weighed
// reset clears phase, indices and the weight register (128); the store is not cleared
module patch_fft_spectral_weighting (
	input  logic                        clk,
	input  logic                        arst_n,
	pfsw_in_if.sink                     item,
	pfsw_out_if.source                  result,
	input  logic                        cfg_we,
	input  logic [pfsw_pkg::CFG_W-1:0]  cfg_data
);
	import pfsw_pkg::*;

	typedef enum logic [2:0] {
		P_LOAD = 3'b001,
		P_FFT  = 3'b010,
		P_READ = 3'b100
	} phase_t;

	phase_t            phase_q;
	logic [ADDR_W-1:0] load_idx_q;
	logic [ADDR_W-1:0] read_idx_q;
	logic [CFG_W-1:0]  weight_q;
	logic              rd_pend_q;
	logic              last_pend_q;
	logic              out_valid_q;
	wbin_t             out_q;
	logic              out_last_q;

	logic              acc;
	load_wr_t          ld;
	bin_rd_t           rd;
	logic              fft_start;
	logic              fft_done;
	cbin_t             rdata;
	wstat_t            wstat;
	wbin_t             wres;
	logic              take;
	logic              read_last;

	// loads take a word every cycle; reads wait for the weight unit
	always_comb begin
		unique case (phase_q)
			P_LOAD:  item.ready = 1'b1;
			P_READ:  item.ready = !rd_pend_q && !wstat.busy;
			default: item.ready = 1'b0;
		endcase
	end

	assign acc = item.valid && item.ready;

	// words of the wrong kind for the phase are taken and dropped
	always_comb begin
		ld.we      = acc && (phase_q == P_LOAD) && !item.action;
		ld.addr    = load_idx_q;
		ld.data.re = {{16{item.sample_re[15]}}, item.sample_re};
		ld.data.im = {{16{item.sample_im[15]}}, item.sample_im};
		rd.en      = acc && (phase_q == P_READ) && item.action;
		rd.addr    = read_idx_q;
	end

	assign fft_start = ld.we && (load_idx_q == ADDR_W'(NBINS - 1));
	assign read_last = read_idx_q == ADDR_W'(NBINS - 1);

	pfsw_fft u_fft (
		.clk    (clk),
		.arst_n (arst_n),
		.ld     (ld),
		.rd     (rd),
		.start  (fft_start),
		.done   (fft_done),
		.rdata  (rdata)
	);

	// store read data is valid in the cycle after the read word
	pfsw_weight u_weight (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rd_pend_q),
		.x      (rdata),
		.alpha  (weight_q),
		.take   (take),
		.stat   (wstat),
		.res    (wres)
	);

	// output register frees the weight unit while the result waits
	assign take = wstat.valid && (!out_valid_q || result.ready);

	assign result.valid    = out_valid_q;
	assign result.bin_re   = out_q.re;
	assign result.bin_im   = out_q.im;
	assign result.last_bin = out_last_q;

	always_ff @(posedge clk) begin
		if (take) begin
			out_q      <= wres;
			out_last_q <= last_pend_q;
		end
		if (rd.en) last_pend_q <= read_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= P_LOAD;
			load_idx_q  <= '0;
			read_idx_q  <= '0;
			weight_q    <= WEIGHT_RESET;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) weight_q <= cfg_data;

			rd_pend_q <= rd.en;

			if (take) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;

			unique case (phase_q)
				P_LOAD: begin
					if (fft_start) begin
						phase_q    <= P_FFT;
						load_idx_q <= '0;
					end else if (ld.we) begin
						load_idx_q <= load_idx_q + ADDR_W'(1);
					end
				end
				P_FFT: begin
					if (fft_done) begin
						phase_q    <= P_READ;
						read_idx_q <= '0;
					end
				end
				P_READ: begin
					if (rd.en) begin
						if (read_last) begin
							// patch done, back to loading
							phase_q    <= P_LOAD;
							read_idx_q <= '0;
							load_idx_q <= '0;
						end else begin
							read_idx_q <= read_idx_q + ADDR_W'(1);
						end
					end
				end
				default: phase_q <= P_LOAD;
			endcase
		end
	end

endmodule
